### hw/rtl/wsp_pkg.sv
package wsp_pkg;

  localparam int PASS_W = 48;
  localparam int TS_W = 24;
  localparam int WGT_W = 16;
  localparam int CH_W = 16;
  localparam int CNT_W = 7;
  localparam int SLOT_W = 6;
  localparam int DEF_NUM_SLOTS = 64;
  localparam logic [TS_W-1:0] TIME_SLICE_RST = TS_W'(10000000);
  localparam logic [PASS_W-1:0] MIN_PRIO_RST = PASS_W'(3);

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_SLEEPING = 2'd2,
    ST_RUNNING = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    ACT_ALLOC = 3'd0,
    ACT_PICK = 3'd1,
    ACT_FINISH = 3'd2,
    ACT_WAKE = 3'd3,
    ACT_SETW = 3'd4
  } act_t;

  localparam logic [1:0] OC_RUN = 2'd0;
  localparam logic [1:0] OC_SLEEP = 2'd1;
  localparam logic [1:0] OC_FREE = 2'd2;

  localparam logic [1:0] RS_DONE = 2'd0;
  localparam logic [1:0] RS_NONE = 2'd1;
  localparam logic [1:0] RS_REFUSED = 2'd2;

  localparam logic CFG_TIME_SLICE = 1'b0;
  localparam logic CFG_MIN_PRIO = 1'b1;

  typedef enum logic [1:0] {
    SC_FREE = 2'd0,
    SC_RUNNABLE = 2'd1,
    SC_READ = 2'd2,
    SC_WAKE = 2'd3
  } scan_mode_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_SCAN1 = 3'd1,
    S_DIV = 3'd2,
    S_SCAN2 = 3'd3,
    S_RESULT = 3'd4
  } state_t;

  // token travelling down the row of cells
  typedef struct packed {
    logic live;
    logic found;
    logic [PASS_W-1:0] pass;
    logic [WGT_W-1:0] weight;
    logic [CNT_W-1:0] count;
  } carrier_t;

  // broadcast write to the addressed cell
  typedef struct packed {
    logic en;
    logic set_status;
    slot_st_t status;
    logic set_pass;
    logic [PASS_W-1:0] pass;
    logic set_weight;
    logic [WGT_W-1:0] weight;
    logic set_chan;
    logic [CH_W-1:0] chan;
  } wr_t;

endpackage

### hw/rtl/wsp_cell.sv
module wsp_cell #(
  parameter int IDX_W = 6,
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  wsp_pkg::scan_mode_t mode,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic [wsp_pkg::CH_W-1:0] wake_chan,
  input  logic [wsp_pkg::PASS_W-1:0] lowest,
  input  wsp_pkg::wr_t wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  wsp_pkg::carrier_t chain_in,
  input  logic [IDX_W-1:0] idx_in,
  output wsp_pkg::carrier_t chain_out,
  output logic [IDX_W-1:0] idx_out
);
  import wsp_pkg::*;

  slot_st_t st;
  logic [PASS_W-1:0] pass;
  logic [WGT_W-1:0] weight;
  logic [CH_W-1:0] chan;

  logic mine_wr, mine_rd, wake_hit, take;
  carrier_t c_next;
  logic [IDX_W-1:0] i_next;

  assign mine_wr = wr.en && (wr_idx == IDX_W'(IDX));
  assign mine_rd = rd_idx == IDX_W'(IDX);
  assign wake_hit = chain_in.live && (mode == SC_WAKE) && (st == ST_SLEEPING) &&
                    (chan == wake_chan);

  // decide whether this cell takes over the token
  always_comb begin
    unique case (mode)
      SC_FREE: take = !chain_in.found && (st == ST_FREE);
      SC_RUNNABLE: take = (st == ST_RUNNABLE) &&
                          (!chain_in.found || (pass < chain_in.pass));
      SC_READ: take = mine_rd;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    c_next = chain_in;
    i_next = idx_in;
    if (take) begin
      c_next.found = 1'b1;
      c_next.pass = pass;
      c_next.weight = weight;
      i_next = IDX_W'(IDX);
    end
    if (wake_hit && (chain_in.count != {CNT_W{1'b1}})) begin
      c_next.count = chain_in.count + 1'b1;
    end
    if (!chain_in.live) begin
      c_next = '0;
      i_next = '0;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_out <= '0;
      idx_out <= '0;
    end else begin
      chain_out <= c_next;
      idx_out <= i_next;
    end
  end

  // slot status
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_FREE;
    end else if (wake_hit) begin
      st <= ST_RUNNABLE;
    end else if (mine_wr && wr.set_status) begin
      st <= wr.status;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (wake_hit) begin
      pass <= lowest;
    end else if (mine_wr && wr.set_pass) begin
      pass <= wr.pass;
    end
    if (mine_wr && wr.set_weight) begin
      weight <= wr.weight;
    end
    if (mine_wr && wr.set_chan) begin
      chan <= wr.chan;
    end
  end

endmodule

### hw/rtl/wsp_div.sv
module wsp_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [wsp_pkg::TS_W-1:0] dividend,
  input  logic [wsp_pkg::WGT_W-1:0] divisor,
  output logic done,
  output logic [wsp_pkg::TS_W-1:0] quotient
);
  import wsp_pkg::*;

  localparam int STEP_W = $clog2(TS_W);

  logic busy;
  logic [STEP_W-1:0] step;
  logic [WGT_W-1:0] rem, dvs;
  logic [WGT_W:0] trial, diff;
  logic ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quotient[TS_W-1]};
  assign ge = trial >= {1'b0, dvs};
  assign diff = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(TS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[WGT_W-1:0] : trial[WGT_W-1:0];
      quotient <= {quotient[TS_W-2:0], ge};
    end
  end

endmodule

### hw/rtl/weighted_stride_task_picker.sv
// channel  | handshake              | beat contents
// cfg      | cfg_we                 | cfg_index, cfg_data
// in       | in_valid / in_ready    | action, new_weight, outcome, channel
// out      | out_valid / out_ready  | status, slot, pass_value, woken_count
// One action at a time. A scan token walks the row of slot cells, one cell a
// cycle. A finish with a task running takes two scans with the divider between
// them. Actions needing no scan go straight to the result step. Reset frees
// every slot at once.
// The result sits in an output register; a stalled out channel holds the
// next result back but never loses one.
module weighted_stride_task_picker #(
  parameter int NUM_SLOTS = wsp_pkg::DEF_NUM_SLOTS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [wsp_pkg::PASS_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] action,
  input  logic [15:0] new_weight,
  input  logic [1:0] outcome,
  input  logic [15:0] channel,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [5:0] slot,
  output logic [47:0] pass_value,
  output logic [6:0] woken_count
);
  import wsp_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);

  state_t state, state_next;

  logic [TS_W-1:0] ts, ts_next;
  logic [PASS_W-1:0] lowest, lowest_next;
  logic [WGT_W-1:0] wc, wc_next;
  logic running_vld, running_vld_next;
  logic [IDX_W-1:0] running_idx, running_idx_next;

  act_t a_action, a_action_next;
  logic [WGT_W-1:0] a_nw, a_nw_next;
  logic [1:0] a_outcome, a_outcome_next;
  logic [CH_W-1:0] a_chan, a_chan_next;

  scan_mode_t scan_mode, scan_mode_next;
  logic inject, inject_next;

  logic [1:0] r_status, r_status_next;
  logic [IDX_W-1:0] r_idx, r_idx_next;
  logic [PASS_W-1:0] r_pass, r_pass_next;
  logic [CNT_W-1:0] r_woken, r_woken_next;

  logic out_valid_next;
  logic [1:0] status_next;
  logic [SLOT_W-1:0] slot_next;
  logic [PASS_W-1:0] pass_value_next;
  logic [CNT_W-1:0] woken_count_next;

  wr_t wr;
  logic [IDX_W-1:0] wr_idx;

  carrier_t chain [NUM_SLOTS+1];
  logic [IDX_W-1:0] cidx [NUM_SLOTS+1];
  carrier_t tail;
  logic [IDX_W-1:0] tail_idx;

  logic div_start, div_done;
  logic [WGT_W-1:0] div_dvs;
  logic [TS_W-1:0] div_q;
  logic [PASS_W:0] sum;
  logic [PASS_W-1:0] p_new;
  logic need_scan, out_free;

  // row of slot cells
  assign chain[0] = inject ? carrier_t'({1'b1, {($bits(carrier_t)-1){1'b0}}}) : '0;
  assign cidx[0] = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    wsp_cell #(.IDX_W(IDX_W), .IDX(g)) u_cell (
      .clk(clk), .rst(rst), .mode(scan_mode), .rd_idx(running_idx),
      .wake_chan(a_chan), .lowest(lowest), .wr(wr), .wr_idx(wr_idx),
      .chain_in(chain[g]), .idx_in(cidx[g]),
      .chain_out(chain[g+1]), .idx_out(cidx[g+1])
    );
  end

  assign tail = chain[NUM_SLOTS];
  assign tail_idx = cidx[NUM_SLOTS];

  // pass increment divider
  assign div_dvs = (tail.weight == '0) ? WGT_W'(1) : tail.weight;

  wsp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(ts), .divisor(div_dvs),
    .done(div_done), .quotient(div_q)
  );

  assign sum = {1'b0, r_pass} + (PASS_W+1)'(div_q);
  assign p_new = sum[PASS_W] ? {PASS_W{1'b1}} : sum[PASS_W-1:0];

  assign need_scan = (action == ACT_ALLOC) || (action == ACT_PICK) ||
                     (action == ACT_WAKE) ||
                     (((action == ACT_FINISH) || (action == ACT_SETW)) && running_vld);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = need_scan ? S_SCAN1 : S_RESULT;
      S_SCAN1: begin
        if (tail.live) begin
          state_next = ((a_action == ACT_FINISH) && (a_outcome <= OC_FREE)) ?
                       S_DIV : S_RESULT;
        end
      end
      S_DIV: if (div_done) state_next = S_SCAN2;
      S_SCAN2: if (tail.live) state_next = S_RESULT;
      S_RESULT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    ts_next = ts;
    lowest_next = lowest;
    wc_next = wc;
    running_vld_next = running_vld;
    running_idx_next = running_idx;
    a_action_next = a_action;
    a_nw_next = a_nw;
    a_outcome_next = a_outcome;
    a_chan_next = a_chan;
    scan_mode_next = scan_mode;
    inject_next = 1'b0;
    r_status_next = r_status;
    r_idx_next = r_idx;
    r_pass_next = r_pass;
    r_woken_next = r_woken;
    out_valid_next = out_valid && !out_ready;
    status_next = status;
    slot_next = slot;
    pass_value_next = pass_value;
    woken_count_next = woken_count;
    wr = '0;
    wr_idx = '0;
    div_start = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          a_action_next = act_t'(action);
          a_nw_next = new_weight;
          a_outcome_next = outcome;
          a_chan_next = channel;
          inject_next = need_scan;
          r_idx_next = '0;
          r_pass_next = '0;
          r_woken_next = '0;
          r_status_next = ((action == ACT_FINISH) || (action == ACT_SETW)) ?
                          RS_NONE : RS_REFUSED;
          unique case (action)
            ACT_ALLOC: scan_mode_next = SC_FREE;
            ACT_PICK: scan_mode_next = running_vld ? SC_READ : SC_RUNNABLE;
            ACT_WAKE: scan_mode_next = SC_WAKE;
            default: scan_mode_next = SC_READ;
          endcase
        end
      end
      S_SCAN1: begin
        if (tail.live) begin
          r_status_next = RS_DONE;
          r_idx_next = tail_idx;
          r_pass_next = tail.pass;
          unique case (a_action)
            ACT_ALLOC: begin
              if (!tail.found) begin
                r_status_next = RS_NONE;
                r_idx_next = '0;
                r_pass_next = '0;
              end else begin
                wr.en = 1'b1;
                wr.set_status = 1'b1;
                wr.status = ST_RUNNABLE;
                wr.set_pass = 1'b1;
                wr.pass = lowest;
                wr.set_weight = 1'b1;
                wr.weight = wc;
                wr_idx = tail_idx;
                r_pass_next = lowest;
                if (wc != {WGT_W{1'b1}}) wc_next = wc + 1'b1;
              end
            end
            ACT_PICK: begin
              if (running_vld) begin
                r_status_next = RS_REFUSED;
              end else if (!tail.found) begin
                r_status_next = RS_NONE;
                r_idx_next = '0;
                r_pass_next = '0;
              end else begin
                wr.en = 1'b1;
                wr.set_status = 1'b1;
                wr.status = ST_RUNNING;
                wr_idx = tail_idx;
                running_vld_next = 1'b1;
                running_idx_next = tail_idx;
              end
            end
            ACT_FINISH: begin
              if (a_outcome > OC_FREE) begin
                r_status_next = RS_REFUSED;
              end else begin
                div_start = 1'b1;
              end
            end
            ACT_WAKE: begin
              r_idx_next = '0;
              r_pass_next = lowest;
              r_woken_next = tail.count;
            end
            default: begin
              if (a_nw == '0) begin
                r_status_next = RS_REFUSED;
              end else begin
                wr.en = 1'b1;
                wr.set_weight = 1'b1;
                wr.weight = a_nw;
                wr_idx = running_idx;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          wr.en = 1'b1;
          wr.set_pass = 1'b1;
          wr.pass = p_new;
          wr.set_status = 1'b1;
          wr.set_chan = (a_outcome == OC_SLEEP);
          wr.chan = a_chan;
          unique case (a_outcome)
            OC_RUN: wr.status = ST_RUNNABLE;
            OC_SLEEP: wr.status = ST_SLEEPING;
            default: wr.status = ST_FREE;
          endcase
          wr_idx = running_idx;
          r_pass_next = p_new;
          running_vld_next = 1'b0;
          scan_mode_next = SC_RUNNABLE;
          inject_next = 1'b1;
        end
      end
      S_SCAN2: begin
        if (tail.live && tail.found) lowest_next = tail.pass;
      end
      default: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next = r_status;
          slot_next = SLOT_W'(r_idx);
          pass_value_next = r_pass;
          woken_count_next = r_woken;
        end
      end
    endcase

    // configuration writes
    if (cfg_we) begin
      if (cfg_index == CFG_TIME_SLICE) begin
        ts_next = cfg_data[TS_W-1:0];
      end else begin
        lowest_next = cfg_data;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ts <= TIME_SLICE_RST;
      lowest <= MIN_PRIO_RST;
      wc <= WGT_W'(1);
      running_vld <= 1'b0;
      inject <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ts <= ts_next;
      lowest <= lowest_next;
      wc <= wc_next;
      running_vld <= running_vld_next;
      inject <= inject_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    running_idx <= running_idx_next;
    a_action <= a_action_next;
    a_nw <= a_nw_next;
    a_outcome <= a_outcome_next;
    a_chan <= a_chan_next;
    scan_mode <= scan_mode_next;
    r_status <= r_status_next;
    r_idx <= r_idx_next;
    r_pass <= r_pass_next;
    r_woken <= r_woken_next;
    status <= status_next;
    slot <= slot_next;
    pass_value <= pass_value_next;
    woken_count <= woken_count_next;
  end

  // checks
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.live |-> (state == S_SCAN1) || (state == S_SCAN2))
    else $error("scan token left the row outside a scan");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_wc_nonzero: assert property (@(posedge clk) disable iff (rst)
    wc != '0)
    else $error("weight counter reached zero");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) && out_free |=> out_valid && (state == S_IDLE))
    else $error("result not placed in output register");

endmodule
